>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SKD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("skd assertion failed");

`define SKD_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("skd forbidden condition seen");

`else

`define SKD_ASSERT(label, clk, rst_n, prop)

`define SKD_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> src/skd_pkg.sv
// ----------------------------------------------------------------------------
// skd_pkg
// Shared types, register codes and 3x3 hit-or-miss templates.
// ----------------------------------------------------------------------------
package skd_pkg;

	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef logic [8:0] win_t;

	typedef struct packed {
		logic is_branch;
		logic is_end;
		logic frame_last;
	} res_t;

	// window bit i = entry i in row-major order, centre is bit 4
	localparam win_t MASK_TOP   = 9'h007;
	localparam win_t MASK_BOT   = 9'h1C0;
	localparam win_t MASK_LEFT  = 9'h049;
	localparam win_t MASK_RIGHT = 9'h124;

	localparam int N_TMPL   = 26;
	localparam int N_BRANCH = 18;

	// cross, T, Y, then end templates
	localparam win_t TMPL_HIT [N_TMPL] = '{
		9'h0BA, 9'h155,
		9'h03A, 9'h055, 9'h09A, 9'h151, 9'h0B8, 9'h154, 9'h0B2, 9'h115,
		9'h095, 9'h11A, 9'h079, 9'h09C, 9'h152, 9'h0B1, 9'h11C, 9'h072,
		9'h090, 9'h110, 9'h030, 9'h014, 9'h012, 9'h011, 9'h018, 9'h050
	};

	localparam win_t TMPL_MISS [N_TMPL] = '{
		9'h145, 9'h0AA,
		9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
		9'h02A, 9'h045, 9'h082, 9'h141, 9'h0A8, 9'h144, 9'h0A2, 9'h105,
		9'h02F, 9'h04F, 9'h0CB, 9'h1C9, 9'h1E8, 9'h1E4, 9'h1A6, 9'h127
	};

	// shift window one column left, new column enters on the right
	function automatic win_t shift_col(win_t w, logic top, logic mid, logic bot);
		return {bot, w[8], w[7], mid, w[5], w[4], top, w[2], w[1]};
	endfunction

endpackage

>>> src/skeleton_keypoint_detector_core.sv
// ----------------------------------------------------------------------------
// skeleton_keypoint_detector_core
// Branch and end point detection on a raster-order binary skeleton stream.
// ----------------------------------------------------------------------------
// Channel  Dir  Content
// s_axis   in   tdata[0] pixel, tuser kind (0 pixel, 1 flush)
// m_axis   out  tdata[0] is_branch, tdata[1] is_end, tlast frame_last
// cfg      in   index 0 frame_width, index 1 frame_height
//
// One request per cycle while s_axis_tready is high; results are registered.
// The line store is read one column ahead through registered read ports.
// m_axis stalls are absorbed by a two-entry output buffer; s_axis_tready
// drops only while both entries are full.
// Reset clears position, window and pending count; line store is not cleared.
// A cfg write restarts the frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skeleton_keypoint_detector_core #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [0] pixel
	input  logic                           s_axis_tuser,  // [0] kind
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // [0] is_branch, [1] is_end
	output logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [skd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [skd_pkg::CFG_W-1:0]      cfg_data
);
	import skd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] col_q, col_d, c;
	logic [RW-1:0] row_q, row_d;
	logic [PW-1:0] pend_q, pend_d;
	win_t          win_q, win_d, win_m, valid_m;
	logic [1:0]    left_q, left_d;
	logic [1:0]    rd_a, rd_b;
	logic          wr_en;
	logic          in_fire, cfg_fire, pend_nz, win_flush;
	logic          c_last, x_last, r_last;
	logic          inv_top, inv_bot, inv_left, inv_right, last_m;
	logic          res_v, m_branch, m_end;
	logic [WW-1:0] w_m1, cfg_w;
	logic [HW-1:0] cfg_h;
	res_t          res, out_res;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_w = WW'(1);
			cfg_h = HW'(1);
		end else begin
			cfg_w = (32'(cfg_data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_data);
			cfg_h = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
		end
	end

	assign pend_nz   = pend_q != '0;
	assign win_flush = pend_q == PW'(w_q) + PW'(1) && h_q != HW'(1);
	assign c         = pend_nz ? '0 : col_q;
	assign w_m1      = w_q - WW'(1);
	assign c_last    = WW'(c) == w_m1;
	assign x_last    = WW'(col_q) == w_m1;
	assign r_last    = HW'(row_q) == h_q - HW'(1);

	always_comb begin
		col_d     = col_q;
		row_d     = row_q;
		pend_d    = pend_q;
		win_d     = win_q;
		left_d    = left_q;
		wr_en     = 1'b0;
		res_v     = 1'b0;
		win_m     = '0;
		inv_top   = 1'b0;
		inv_bot   = 1'b0;
		inv_left  = 1'b0;
		inv_right = 1'b0;
		last_m    = 1'b0;
		if (cfg_fire) begin
			col_d  = '0;
			row_d  = '0;
			pend_d = '0;
			win_d  = '0;
		end else if (in_fire) begin
			if (s_axis_tuser == KIND_FLUSH) begin
				if (pend_nz) begin
					res_v  = 1'b1;
					pend_d = pend_q - PW'(1);
					if (win_flush) begin
						// second to last row, last column
						win_m     = shift_col(win_q, 1'b0, 1'b0, 1'b0);
						inv_top   = h_q == HW'(2);
						inv_left  = w_q == WW'(1);
						inv_right = 1'b1;
					end else begin
						// last row, rebuilt from the line store
						win_m     = {3'b000, rd_b[0], rd_a[0], left_q[0],
							rd_b[1], rd_a[1], left_q[1]};
						inv_top   = h_q == HW'(1);
						inv_bot   = 1'b1;
						inv_left  = col_q == '0;
						inv_right = x_last;
						last_m    = x_last;
						left_d    = rd_a;
						col_d     = x_last ? '0 : col_q + CW'(1);
					end
				end
			end else begin
				pend_d = '0;
				wr_en  = 1'b1;
				win_d  = shift_col(win_q, rd_a[1], rd_a[0], s_axis_tdata[0]);
				if (c != '0 && row_q != '0) begin
					res_v    = 1'b1;
					win_m    = win_d;
					inv_top  = row_q == RW'(1);
					inv_left = c == CW'(1);
				end else if (c == '0 && row_q > RW'(1)) begin
					res_v     = 1'b1;
					win_m     = shift_col(win_q, 1'b0, 1'b0, 1'b0);
					inv_top   = row_q == RW'(2);
					inv_left  = w_q == WW'(1);
					inv_right = 1'b1;
				end
				if (c_last) begin
					col_d = '0;
					if (r_last) begin
						row_d  = '0;
						pend_d = (h_q != HW'(1)) ? PW'(w_q) + PW'(1) : PW'(w_q);
					end else begin
						row_d = row_q + RW'(1);
					end
				end else begin
					col_d = c + CW'(1);
				end
			end
		end
	end

	assign valid_m = ~((inv_top ? MASK_TOP : '0) | (inv_bot ? MASK_BOT : '0) |
		(inv_left ? MASK_LEFT : '0) | (inv_right ? MASK_RIGHT : '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WW'(RST_W);
			h_q    <= HW'(RST_H);
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			win_q  <= '0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  w_q <= cfg_w;
					REG_FRAME_HEIGHT: h_q <= cfg_h;
					default:          ;
				endcase
			end
			col_q  <= col_d;
			row_q  <= row_d;
			pend_q <= pend_d;
			win_q  <= win_d;
		end
	end

	always_ff @(posedge clk) begin
		left_q <= left_d;
	end

	skd_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (c),
		.wr_data   ({rd_a[0], s_axis_tdata[0]}),
		.rd_addr_a (col_d),
		.rd_addr_b (col_d + CW'(1)),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	skd_match u_match (
		.win       (win_m),
		.valid     (valid_m),
		.is_branch (m_branch),
		.is_end    (m_end)
	);

	assign res = '{is_branch: m_branch, is_end: m_end, frame_last: last_m};

	skd_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_v),
		.push_data  (res),
		.push_ready (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_data   (out_res),
		.out_ready  (m_axis_tready)
	);

	assign m_axis_tdata = {6'b000000, out_res.is_end, out_res.is_branch};
	assign m_axis_tlast = out_res.frame_last;

	`SKD_ASSERT(a_skid_implies_out, clk, arst_n, !s_axis_tready |-> m_axis_tvalid)
	`SKD_ASSERT(a_pend_bound, clk, arst_n, PW'(w_q) + PW'(1) >= pend_q)
	`SKD_ASSERT(a_col_in_frame, clk, arst_n, WW'(col_q) < w_q)
	`SKD_ASSERT(a_pend_row_zero, clk, arst_n, pend_nz |-> row_q == '0)

endmodule

>>> src/skd_line_store.sv
// ----------------------------------------------------------------------------
// skd_line_store
// Two-row line buffer, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module skd_line_store #(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,   // [1] upper row, [0] middle row
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [1:0]    rd_data_a,
	output logic [1:0]    rd_data_b
);

	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// write-through on same-address access
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == rd_addr_a) begin
			rd_data_a <= wr_data;
		end else begin
			rd_data_a <= mem[rd_addr_a];
		end
		if (wr_en && wr_addr == rd_addr_b) begin
			rd_data_b <= wr_data;
		end else begin
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

>>> src/skd_match.sv
// ----------------------------------------------------------------------------
// skd_match
// Hit-or-miss match of a 3x3 window against the branch and end templates.
// ----------------------------------------------------------------------------
module skd_match (
	input  skd_pkg::win_t win,
	input  skd_pkg::win_t valid,   // 0 = outside frame, don't care
	output logic          is_branch,
	output logic          is_end
);
	import skd_pkg::*;

	logic [N_TMPL-1:0] hit;

	always_comb begin
		for (int i = 0; i < N_TMPL; i++) begin
			hit[i] = ((TMPL_HIT[i] & valid & ~win) == '0) &&
				((TMPL_MISS[i] & valid & win) == '0);
		end
	end

	assign is_branch = |hit[N_BRANCH-1:0];
	assign is_end    = |hit[N_TMPL-1:N_BRANCH];

endmodule

>>> src/skd_out_buf.sv
// ----------------------------------------------------------------------------
// skd_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module skd_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  skd_pkg::res_t push_data,
	output logic          push_ready,
	output logic          out_valid,
	output skd_pkg::res_t out_data,
	input  logic          out_ready
);
	import skd_pkg::*;

	logic out_v_q;
	logic skid_v_q;
	res_t out_q;
	res_t skid_q;
	logic pop;

	assign pop = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= push;
			end else begin
				out_v_q  <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_v_q ? skid_q : push_data;
			if (push) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign push_ready = !skid_v_q;
	assign out_valid  = out_v_q;
	assign out_data   = out_q;

endmodule

>>> test/skeleton_keypoint_detector_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skeleton_keypoint_detector_core_tb
// Streams binary skeleton frames through the core and checks the branch, end and
// frame_last flags of every result against a cycle-free prediction of the 3x3
// hit-or-miss matching, under random stalls on both stream sides.
// ----------------------------------------------------------------------------
module skeleton_keypoint_detector_core_tb;
	import skd_pkg::*;

	localparam int SIZE_LIMIT   = 2048;
	localparam int HOLD_OFF     = 6;
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int SHOW_LIMIT   = 50;

	// plus shape in a 3x3 frame, first pixel in the top bit
	localparam bit [8:0] PLUS_SHAPE = 9'b010_111_010;

	// per template: window bits that must be foreground / background
	localparam bit [8:0] FG_NEED [26] = '{
		9'h0BA, 9'h155,
		9'h03A, 9'h055, 9'h09A, 9'h151, 9'h0B8, 9'h154, 9'h0B2, 9'h115,
		9'h095, 9'h11A, 9'h079, 9'h09C, 9'h152, 9'h0B1, 9'h11C, 9'h072,
		9'h090, 9'h110, 9'h030, 9'h014, 9'h012, 9'h011, 9'h018, 9'h050
	};
	localparam bit [8:0] BG_NEED [26] = '{
		9'h145, 9'h0AA,
		9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
		9'h02A, 9'h045, 9'h082, 9'h141, 9'h0A8, 9'h144, 9'h0A2, 9'h105,
		9'h02F, 9'h04F, 9'h0CB, 9'h1C9, 9'h1E8, 9'h1E4, 9'h1A6, 9'h127
	};
	localparam int BRANCH_SHAPES = 18;

	class keypoint_checker;
		bit [CFG_W-1:0] width_reg;
		bit [CFG_W-1:0] height_reg;
		bit             upper_row [SIZE_LIMIT];
		bit             middle_row [SIZE_LIMIT];
		bit [8:0]       window;
		int unsigned    col;
		int unsigned    row;
		int unsigned    pending;
		res_t           flags_due [$];
		int unsigned    mismatches;
		int unsigned    useful_requests;

		function new();
			width_reg = CFG_W'(640);
			height_reg = CFG_W'(480);
			mismatches = 0;
			useful_requests = 0;
			restart();
		endfunction

		function void restart();
			window = '0;
			col = 0;
			row = 0;
			pending = 0;
		endfunction

		function int unsigned clamped(int unsigned v);
			if (v == 0)
				return 1;
			if (v > SIZE_LIMIT)
				return SIZE_LIMIT;
			return v;
		endfunction

		function bit [8:0] shifted(bit [8:0] w, bit top, bit mid, bit bot);
			return ((w >> 1) & 9'h0DB) | {bot, 2'b00, mid, 2'b00, top, 2'b00};
		endfunction

		function res_t classify(bit [8:0] w, int unsigned y, int unsigned x);
			int unsigned wd;
			int unsigned ht;
			bit [8:0]    care;
			res_t        r;
			int          i;
			wd = clamped(32'(width_reg));
			ht = clamped(32'(height_reg));
			care = 9'h1FF;
			if (y == 0)
				care &= ~9'h007;
			if (y + 1 >= ht)
				care &= ~9'h1C0;
			if (x == 0)
				care &= ~9'h049;
			if (x + 1 >= wd)
				care &= ~9'h124;
			r = '0;
			for (i = 0; i < 26; i++) begin
				if (((FG_NEED[i] & care & ~w) == 0) && ((BG_NEED[i] & care & w) == 0)) begin
					if (i < BRANCH_SHAPES)
						r.is_branch = 1'b1;
					else
						r.is_end = 1'b1;
				end
			end
			r.frame_last = (y + 1 == ht) && (x + 1 == wd);
			return r;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			if (idx == REG_FRAME_WIDTH)
				width_reg = v;
			else
				height_reg = v;
			restart();
		endfunction

		function void predict_request(logic kind, logic pix);
			int unsigned wd;
			int unsigned ht;
			int unsigned x;
			int unsigned y;
			int unsigned d;
			bit [8:0]    w;
			bit [8:0]    prev;
			bit          top;
			bit          mid;
			wd = clamped(32'(width_reg));
			ht = clamped(32'(height_reg));
			if (kind == KIND_FLUSH) begin
				if (pending == 0)
					return;
				useful_requests++;
				if (pending == wd + 1 && ht >= 2) begin
					w = shifted(window, 1'b0, 1'b0, 1'b0);
					y = ht - 2;
					x = wd - 1;
				end else begin
					x = (pending <= wd) ? wd - pending : 0;
					y = ht - 1;
					w = '0;
					for (d = 0; d < 3; d++) begin
						if (x + d >= 1 && x + d - 1 < wd) begin
							w[d] = upper_row[x + d - 1];
							w[3 + d] = middle_row[x + d - 1];
						end
					end
				end
				flags_due.push_back(classify(w, y, x));
				pending--;
				return;
			end
			useful_requests++;
			pending = 0;
			if (col >= wd || row >= ht) begin
				col = 0;
				row = 0;
			end
			prev = window;
			top = upper_row[col];
			mid = middle_row[col];
			window = shifted(prev, top, mid, pix);
			upper_row[col] = mid;
			middle_row[col] = pix;
			if (col >= 1 && row >= 1)
				flags_due.push_back(classify(window, row - 1, col - 1));
			else if (col == 0 && row >= 2)
				flags_due.push_back(classify(shifted(prev, 1'b0, 1'b0, 1'b0), row - 2, wd - 1));
			col++;
			if (col >= wd) begin
				col = 0;
				row++;
				if (row >= ht) begin
					row = 0;
					pending = (ht >= 2) ? wd + 1 : wd;
				end
			end
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_flags(res_t got);
			res_t want;
			if (flags_due.size() == 0) begin
				report($sformatf("result with none outstanding (%b%b%b)",
					got.is_branch, got.is_end, got.frame_last));
				return;
			end
			want = flags_due.pop_front();
			if (got.is_branch !== want.is_branch)
				report($sformatf("is_branch %b, want %b", got.is_branch, want.is_branch));
			if (got.is_end !== want.is_end)
				report($sformatf("is_end %b, want %b", got.is_end, want.is_end));
			if (got.frame_last !== want.frame_last)
				report($sformatf("frame_last %b, want %b", got.frame_last, want.frame_last));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_valid;
	logic                 s_ready;
	logic [7:0]           s_data;  // [0] pixel
	logic                 s_user;  // [0] kind
	logic                 m_valid;
	logic                 m_ready;
	logic [7:0]           m_data;  // [0] is_branch, [1] is_end
	logic                 m_last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	keypoint_checker sb;
	bit              s_idle_on;
	bit              m_idle_on;
	int unsigned     cur_w;
	int unsigned     cur_h;
	int unsigned     quiet_cycles = 0;

	skeleton_keypoint_detector_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tlast  (m_last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin : sample
		res_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (s_valid && s_ready)
				sb.predict_request(s_user, s_data[0]);
			if (m_valid && m_ready) begin
				got.is_branch = m_data[0];
				got.is_end = m_data[1];
				got.frame_last = m_last;
				sb.check_flags(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		m_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (m_idle_on && $urandom_range(0, 5) == 0) begin
				m_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_req(input logic kind, input logic pix);
		if (s_idle_on && $urandom_range(0, 5) == 0) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_user <= kind;
		s_data <= {7'b0, pix};
		do @(posedge clk); while (!s_ready);
	endtask

	task automatic pause_until_drained();
		s_valid <= 1'b0;
		do @(posedge clk); while (sb.flags_due.size() != 0);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		pause_until_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			cur_w = 32'(value);
		else
			cur_h = 32'(value);
	endtask

	task automatic run_frame(input int unsigned wd, input int unsigned ht, input bit ragged);
		int unsigned flushes;
		int unsigned density;
		int unsigned mode;
		int unsigned n;
		density = 15 + 20 * $urandom_range(0, 3);
		flushes = (ht >= 2) ? wd + 1 : wd;
		mode = ragged ? $urandom_range(0, 9) : 9;
		// cut short: the next pixel drops the rest; surplus flushes are ignored
		if (mode == 0)
			flushes = $urandom_range(0, flushes);
		else if (mode == 1)
			flushes += $urandom_range(1, 3);
		for (n = 0; n < wd * ht; n++) begin
			if (ragged && $urandom_range(0, 299) == 0)
				pause_until_drained();
			send_req(KIND_PIXEL, $urandom_range(0, 99) < density);
		end
		repeat (flushes) send_req(KIND_FLUSH, $urandom_range(0, 1) != 0);
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 30))
			send_req($urandom_range(0, 3) == 0, $urandom_range(0, 1) != 0);
	endtask

	task automatic random_phase();
		int unsigned pick;
		int unsigned wv;
		int unsigned hv;
		int unsigned which;
		int unsigned area;
		s_idle_on = ($urandom_range(0, 3) != 0);
		m_idle_on = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 9);
		wv = $urandom_range(1, 8);
		hv = $urandom_range(1, 6);
		if (pick == 7)
			wv = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(2049, 4095);
		else if (pick == 8)
			hv = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(2049, 4095);
		else if (pick == 9) begin
			wv = $urandom_range(0, 4095);
			hv = $urandom_range(0, 4095);
		end
		which = $urandom_range(0, 4);
		if (which == 1 || which >= 3)
			write_reg(REG_FRAME_WIDTH, wv[CFG_W-1:0]);
		if (which >= 2)
			write_reg(REG_FRAME_HEIGHT, hv[CFG_W-1:0]);
		area = sb.clamped(cur_w) * sb.clamped(cur_h);
		repeat ($urandom_range(1, 3)) begin
			if (area <= 64 && $urandom_range(0, 4) != 0)
				run_frame(sb.clamped(cur_w), sb.clamped(cur_h), 1'b1);
			else
				run_noise();
		end
	endtask

	initial begin
		int unsigned target;
		int          i;
		sb = new();
		cur_w = 640;
		cur_h = 480;
		s_idle_on = 1'b0;
		m_idle_on = 1'b0;
		arst_n <= 1'b0;
		s_valid <= 1'b0;
		s_user <= KIND_PIXEL;
		s_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flush with nothing pending
		send_req(KIND_FLUSH, 1'b1);
		// plus shape in a 3x3 frame: branch at the centre, ends on the arms
		write_reg(REG_FRAME_WIDTH, 12'd3);
		write_reg(REG_FRAME_HEIGHT, 12'd3);
		for (i = 8; i >= 0; i--)
			send_req(KIND_PIXEL, PLUS_SHAPE[i]);
		pause_until_drained();
		repeat (5) send_req(KIND_FLUSH, 1'b0);
		// zero sizes count as a 1x1 frame
		write_reg(REG_FRAME_WIDTH, 12'd0);
		write_reg(REG_FRAME_HEIGHT, 12'd0);
		send_req(KIND_PIXEL, 1'b1);
		send_req(KIND_FLUSH, 1'b0);
		send_req(KIND_PIXEL, 1'b0);
		send_req(KIND_FLUSH, 1'b1);
		send_req(KIND_PIXEL, 1'b1);
		send_req(KIND_PIXEL, 1'b0);
		send_req(KIND_FLUSH, 1'b0);

		target = sb.useful_requests + RANDOM_ITEMS;
		while (sb.useful_requests < target)
			random_phase();

		// closing frames, no idling from here on
		s_idle_on = 1'b0;
		m_idle_on = 1'b0;
		write_reg(REG_FRAME_WIDTH, 12'd8);
		write_reg(REG_FRAME_HEIGHT, 12'd6);
		run_frame(8, 6, 1'b0);
		write_reg(REG_FRAME_WIDTH, 12'd1);
		write_reg(REG_FRAME_HEIGHT, 12'd8);
		run_frame(1, 8, 1'b0);

		pause_until_drained();
		repeat (HOLD_OFF) @(posedge clk);
		if (sb.mismatches == 0 && sb.flags_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
